// ----- hdl/lru2d_pkg.sv -----
package lru2d_pkg;

  typedef enum logic {
    OP_PROBE  = 1'b0,
    OP_ACCESS = 1'b1
  } opcode_t;

  // Recency update applied to the rank cells for one beat.
  typedef struct packed {
    logic touch;   // present key moves to most recent
    logic insert;  // new key enters as most recent, the rest age
  } upd_t;

  localparam int SLOT_W = 6;
  localparam int OCC_W  = 7;
  localparam int FIELD_W = 16;

endpackage

// ----- hdl/lru2d_tag_array.sv -----
module lru2d_tag_array #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic [CAPACITY-1:0]  entry_valid,
  input  logic [KEY_WIDTH-1:0] key_x,
  input  logic [KEY_WIDTH-1:0] key_y,
  input  logic                 we,
  input  logic [CAPACITY-1:0]  wr_sel,
  input  logic [CAPACITY-1:0]  rd_sel,
  output logic [CAPACITY-1:0]  match,
  output logic [KEY_WIDTH-1:0] rd_x,
  output logic [KEY_WIDTH-1:0] rd_y
);

  logic [KEY_WIDTH-1:0] stored_x [CAPACITY];
  logic [KEY_WIDTH-1:0] stored_y [CAPACITY];

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (we && wr_sel[i]) begin
        stored_x[i] <= key_x;
        stored_y[i] <= key_y;
      end
    end
  end

  // Valid keys are distinct, so at most one cell matches.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = entry_valid[i] && (stored_x[i] == key_x) && (stored_y[i] == key_y);
    end
  end

  // One-hot select: OR the selected cell's key onto the read bus.
  always_comb begin
    rd_x = '0;
    rd_y = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_sel[i]) begin
        rd_x = rd_x | stored_x[i];
        rd_y = rd_y | stored_y[i];
      end
    end
  end

endmodule

// ----- hdl/lru2d_rank_array.sv -----
module lru2d_rank_array #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic [CAPACITY-1:0] entry_valid,
  input  logic [CAPACITY-1:0] match,
  input  logic [CAPACITY-1:0] wr_sel,
  input  lru2d_pkg::upd_t     upd,
  output logic [CAPACITY-1:0] lru_sel
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(CAPACITY - 1);

  logic [RANK_W-1:0] rank [CAPACITY];
  logic [RANK_W-1:0] hit_rank;

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_rank = hit_rank | rank[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lru_sel[i] = entry_valid[i] && (rank[i] == RANK_OLDEST);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (upd.touch) begin
        if (match[i]) begin
          rank[i] <= '0;
        end else if (entry_valid[i] && (rank[i] < hit_rank)) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end else if (upd.insert) begin
        // full store: the oldest cell is the one rewritten, so no rank overflows
        if (wr_sel[i]) begin
          rank[i] <= '0;
        end else if (entry_valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/lru_tag_cache_2d_key_unit.sv -----
// Fully associative LRU tag store keyed by a signed (x, y) coordinate.
// Request channel: req_valid / req_stall with opcode, key_x, key_y; a beat
// moves on a rising edge with req_valid high and req_stall low. A probe
// reports presence only; an access touches a present key or inserts an
// absent one, evicting the least recent key when the store is full.
// Response channel: rsp_valid / rsp_stall with hit, slot, evicted,
// evicted_x, evicted_y and occupancy, exactly one beat per request.
// Pipeline: the input register holds the request, then the response register
// holds the result. Throughput: one item per cycle while the receiver does
// not stall, set by the parallel tag compare and rank update over all cells.
// Slot indexes let external memory hold per-key payload.
// Reset (rst, synchronous) empties the store and drops both pipeline
// registers; key and rank cells are not cleared. When the receiver stalls,
// the response holds, the input register fills, and req_stall rises.
module lru_tag_cache_2d_key_unit #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [15:0] key_x,
  input  logic [15:0] key_y,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic [5:0]  slot,
  output logic        evicted,
  output logic [15:0] evicted_x,
  output logic [15:0] evicted_y,
  output logic [6:0]  occupancy
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // input register
  logic                     held_valid;
  lru2d_pkg::opcode_t       held_op;
  logic [KEY_WIDTH-1:0]     held_x;
  logic [KEY_WIDTH-1:0]     held_y;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic                     advance;
  logic                     accept;
  logic [KEY_WIDTH+15:0]    in_x_ext;
  logic [KEY_WIDTH+15:0]    in_y_ext;

  logic [CAPACITY-1:0]      entry_valid;
  logic [CAPACITY-1:0]      cnt_sel;
  logic [CAPACITY-1:0]      match;
  logic [CAPACITY-1:0]      lru_sel;
  logic [CAPACITY-1:0]      wr_sel;
  logic [KEY_WIDTH-1:0]     rd_x;
  logic [KEY_WIDTH-1:0]     rd_y;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         lru_idx;
  logic [IDX_W-1:0]         res_idx;
  logic [IDX_W+5:0]         res_idx_ext;
  logic [CNT_W+6:0]         occ_ext;
  logic [KEY_WIDTH+15:0]    ev_x_ext;
  logic [KEY_WIDTH+15:0]    ev_y_ext;
  logic                     is_hit;
  logic                     full;
  lru2d_pkg::upd_t          upd;

  assign advance   = held_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = held_valid && !advance;
  assign accept    = req_valid && !req_stall;

  assign in_x_ext = {KEY_WIDTH'(0), key_x};
  assign in_y_ext = {KEY_WIDTH'(0), key_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op <= lru2d_pkg::opcode_t'(opcode);
      held_x  <= in_x_ext[KEY_WIDTH-1:0];
      held_y  <= in_y_ext[KEY_WIDTH-1:0];
    end
  end

  // Entries never leave once filled, so the valid cells are exactly the
  // lowest count slots and the next free slot is count itself.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign entry_valid[g] = count > CNT_W'(g);
      assign cnt_sel[g]     = count == CNT_W'(g);
    end
  endgenerate

  assign full = (count == CNT_FULL);

  lru2d_tag_array #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_tag (
    .clk         (clk),
    .entry_valid (entry_valid),
    .key_x       (held_x),
    .key_y       (held_y),
    .we          (upd.insert),
    .wr_sel      (wr_sel),
    .rd_sel      (lru_sel),
    .match       (match),
    .rd_x        (rd_x),
    .rd_y        (rd_y)
  );

  lru2d_rank_array #(
    .CAPACITY (CAPACITY)
  ) u_rank (
    .clk         (clk),
    .entry_valid (entry_valid),
    .match       (match),
    .wr_sel      (wr_sel),
    .upd         (upd),
    .lru_sel     (lru_sel)
  );

  assign is_hit = |match;
  assign wr_sel = full ? lru_sel : cnt_sel;

  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (lru_sel[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    upd.touch  = advance && (held_op == lru2d_pkg::OP_ACCESS) && is_hit;
    upd.insert = advance && (held_op == lru2d_pkg::OP_ACCESS) && !is_hit;
  end

  assign count_next = count + CNT_W'(upd.insert && !full);

  always_comb begin
    if (is_hit) begin
      res_idx = hit_idx;
    end else if (held_op != lru2d_pkg::OP_ACCESS) begin
      res_idx = '0;
    end else if (full) begin
      res_idx = lru_idx;
    end else begin
      res_idx = count[IDX_W-1:0];
    end
  end

  assign res_idx_ext = {6'b0, res_idx};
  assign occ_ext     = {7'b0, count_next};
  // sign-extend the evicted key from its stored width, then cut to the field
  assign ev_x_ext    = {{16{rd_x[KEY_WIDTH-1]}}, rd_x};
  assign ev_y_ext    = {{16{rd_y[KEY_WIDTH-1]}}, rd_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit       <= is_hit;
      slot      <= res_idx_ext[lru2d_pkg::SLOT_W-1:0];
      evicted   <= upd.insert && full;
      evicted_x <= (upd.insert && full) ? ev_x_ext[lru2d_pkg::FIELD_W-1:0] : '0;
      evicted_y <= (upd.insert && full) ? ev_y_ext[lru2d_pkg::FIELD_W-1:0] : '0;
      occupancy <= occ_ext[lru2d_pkg::OCC_W-1:0];
    end
  end

endmodule

// ----- hdl/lru2d_checker.sv -----
module lru2d_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        hit,
  input logic [5:0]  slot,
  input logic        evicted,
  input logic [15:0] evicted_x,
  input logic [15:0] evicted_y,
  input logic [6:0]  occupancy
);

  localparam logic [6:0] OCC_FULL = 7'(CAPACITY % 128);

  // a stalled response beat holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable({hit, slot, evicted, evicted_x,
                                                      evicted_y, occupancy}))
    else $error("stalled response changed");

  // eviction happens only on an insert, never on a hit
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && evicted))
    else $error("hit and eviction in one beat");

  // eviction only from a full store, which stays full
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted |-> occupancy == OCC_FULL)
    else $error("eviction without a full store");

  // no eviction reports a zero key
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted |-> evicted_x == 16'd0 && evicted_y == 16'd0)
    else $error("evicted key without eviction");

  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_tag_cache_2d_key_unit lru2d_checker #(
  .CAPACITY (CAPACITY)
) u_lru2d_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .hit       (hit),
  .slot      (slot),
  .evicted   (evicted),
  .evicted_x (evicted_x),
  .evicted_y (evicted_y),
  .occupancy (occupancy)
);

// ----- dv/lru_tag_cache_2d_key_unit_test.sv -----
`timescale 1ns / 1ps

module lru_tag_cache_2d_key_unit_test;

  localparam int CAP       = 64;
  localparam int N_DIRECT  = 19;
  localparam int N_SEGS    = 8;
  localparam int SEG_LEN   = 104;
  localparam int POOL_SIZE = 128;
  localparam int DRAIN     = 10;
  localparam int LIMIT     = 200000;

  localparam lru2d_pkg::opcode_t PROBE  = lru2d_pkg::OP_PROBE;
  localparam lru2d_pkg::opcode_t ACCESS = lru2d_pkg::OP_ACCESS;

  typedef struct packed {
    logic             hit;
    logic [5:0]       slot;
    logic             evicted;
    logic [15:0]      ev_x;
    logic [15:0]      ev_y;
    logic [6:0]       occ;
  } lookup_rsp_t;

  typedef struct packed {
    lru2d_pkg::opcode_t op;
    logic [15:0]        kx;
    logic [15:0]        ky;
    logic               typed;
    lookup_rsp_t        rsp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        opcode = 1'b0;
  logic [15:0] key_x = '0;
  logic [15:0] key_y = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        hit;
  logic [5:0]  slot;
  logic        evicted;
  logic [15:0] evicted_x;
  logic [15:0] evicted_y;
  logic [6:0]  occupancy;

  // tag store mirror
  logic [15:0] tag_x [CAP];
  logic [15:0] tag_y [CAP];
  bit          tag_vld [CAP];
  int unsigned age [CAP];
  int unsigned n_valid;

  lookup_rsp_t pending_rsp[$];
  dir_row_t    dir_rows [N_DIRECT];
  logic [15:0] pool_x [POOL_SIZE];
  logic [15:0] pool_y [POOL_SIZE];

  bit quiet = 1'b0;
  int errors = 0;
  int cycles = 0;
  int n_beats = 0, n_probes = 0, n_hits = 0, n_evicts = 0, peak_occ = 0;

  lru_tag_cache_2d_key_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (opcode),
    .key_x     (key_x),
    .key_y     (key_y),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .slot      (slot),
    .evicted   (evicted),
    .evicted_x (evicted_x),
    .evicted_y (evicted_y),
    .occupancy (occupancy)
  );

  always #5 clk = ~clk;

  function automatic lookup_rsp_t cache_lookup(lru2d_pkg::opcode_t op, logic [15:0] kx,
                                               logic [15:0] ky);
    lookup_rsp_t r;
    bit          found;
    int          idx;
    int unsigned lim;
    int unsigned best;
    r = '0;
    found = 1'b0;
    idx = 0;
    for (int i = 0; i < CAP; i++) begin
      if (!found && tag_vld[i] && tag_x[i] == kx && tag_y[i] == ky) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (op == ACCESS) begin
      if (found) begin
        lim = age[idx];
        for (int i = 0; i < CAP; i++)
          if (tag_vld[i] && age[i] < lim) age[i]++;
        age[idx] = 0;
      end else if (n_valid < CAP) begin
        idx = -1;
        for (int i = CAP - 1; i >= 0; i--)
          if (!tag_vld[i]) idx = i;
        for (int i = 0; i < CAP; i++)
          if (tag_vld[i]) age[i]++;
        tag_vld[idx] = 1'b1;
        tag_x[idx] = kx;
        tag_y[idx] = ky;
        age[idx] = 0;
        n_valid++;
      end else begin
        // replace the oldest entry
        best = 0;
        for (int i = 0; i < CAP; i++) begin
          if (tag_vld[i] && age[i] >= best) begin
            best = age[i];
            idx = i;
          end
        end
        r.evicted = 1'b1;
        r.ev_x = tag_x[idx];
        r.ev_y = tag_y[idx];
        for (int i = 0; i < CAP; i++)
          if (tag_vld[i] && i != idx) age[i]++;
        tag_x[idx] = kx;
        tag_y[idx] = ky;
        age[idx] = 0;
        n_evicts++;
      end
    end else begin
      n_probes++;
    end
    r.hit = found;
    r.slot = (found || op == ACCESS) ? idx[5:0] : '0;
    r.occ = n_valid[6:0];
    if (found) n_hits++;
    if (n_valid > peak_occ) peak_occ = n_valid;
    n_beats++;
    return r;
  endfunction

  // Present one request beat after a random idle gap; return the predicted result.
  task automatic send_req(input lru2d_pkg::opcode_t op, input logic [15:0] kx,
                          input logic [15:0] ky, output lookup_rsp_t pred);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    key_x     <= kx;
    key_y     <= ky;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = cache_lookup(op, kx, ky);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_rsp.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    lookup_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result beat, hit %b slot %0d", $time, hit, slot);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("hit", {15'b0, want.hit}, {15'b0, hit});
        check_field("slot", {10'b0, want.slot}, {10'b0, slot});
        check_field("evicted", {15'b0, want.evicted}, {15'b0, evicted});
        check_field("evicted_x", want.ev_x, evicted_x);
        check_field("evicted_y", want.ev_y, evicted_y);
        check_field("occupancy", {9'b0, want.occ}, {9'b0, occupancy});
      end
    end
  end

  // receiver: hold off a random number of cycles before taking each beat
  initial begin
    int w;
    wait (!rst);
    @(posedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  initial begin
    lookup_rsp_t        pred;
    lru2d_pkg::opcode_t op;
    logic [15:0]        kx, ky;
    int                 pool_n, j;

    for (int i = 0; i < CAP; i++) begin
      tag_x[i] = '0;
      tag_y[i] = '0;
      tag_vld[i] = 1'b0;
      age[i] = 0;
    end
    n_valid = 0;

    dir_rows[0]  = '{PROBE,  16'h0000, 16'h0000, 1'b1, '{1'b0, 6'd0, 1'b0, 16'h0, 16'h0, 7'd0}};
    dir_rows[1]  = '{ACCESS, 16'h8000, 16'h7fff, 1'b1, '{1'b0, 6'd0, 1'b0, 16'h0, 16'h0, 7'd1}};
    dir_rows[2]  = '{ACCESS, 16'h7fff, 16'h8000, 1'b1, '{1'b0, 6'd1, 1'b0, 16'h0, 16'h0, 7'd2}};
    dir_rows[3]  = '{ACCESS, 16'hffff, 16'hffff, 1'b1, '{1'b0, 6'd2, 1'b0, 16'h0, 16'h0, 7'd3}};
    dir_rows[4]  = '{ACCESS, 16'h0000, 16'h0000, 1'b1, '{1'b0, 6'd3, 1'b0, 16'h0, 16'h0, 7'd4}};
    dir_rows[5]  = '{PROBE,  16'h8000, 16'h7fff, 1'b1, '{1'b1, 6'd0, 1'b0, 16'h0, 16'h0, 7'd4}};
    // one coordinate matches a stored key, the other does not
    dir_rows[6]  = '{PROBE,  16'h7fff, 16'h7fff, 1'b1, '{1'b0, 6'd0, 1'b0, 16'h0, 16'h0, 7'd4}};
    dir_rows[7]  = '{PROBE,  16'h8000, 16'h8000, 1'b1, '{1'b0, 6'd0, 1'b0, 16'h0, 16'h0, 7'd4}};
    // touch the most recent entry, then the oldest
    dir_rows[8]  = '{ACCESS, 16'h0000, 16'h0000, 1'b1, '{1'b1, 6'd3, 1'b0, 16'h0, 16'h0, 7'd4}};
    dir_rows[9]  = '{ACCESS, 16'h8000, 16'h7fff, 1'b1, '{1'b1, 6'd0, 1'b0, 16'h0, 16'h0, 7'd4}};
    dir_rows[10] = '{ACCESS, 16'h0001, 16'h0000, 1'b1, '{1'b0, 6'd4, 1'b0, 16'h0, 16'h0, 7'd5}};
    dir_rows[11] = '{ACCESS, 16'h0000, 16'h0001, 1'b1, '{1'b0, 6'd5, 1'b0, 16'h0, 16'h0, 7'd6}};
    dir_rows[12] = '{ACCESS, 16'h5555, 16'haaaa, 1'b1, '{1'b0, 6'd6, 1'b0, 16'h0, 16'h0, 7'd7}};
    dir_rows[13] = '{ACCESS, 16'haaaa, 16'h5555, 1'b1, '{1'b0, 6'd7, 1'b0, 16'h0, 16'h0, 7'd8}};
    dir_rows[14] = '{PROBE,  16'hffff, 16'hffff, 1'b1, '{1'b1, 6'd2, 1'b0, 16'h0, 16'h0, 7'd8}};
    dir_rows[15] = '{ACCESS, 16'h7fff, 16'h8000, 1'b0, '0};
    dir_rows[16] = '{PROBE,  16'h0001, 16'h0000, 1'b0, '0};
    dir_rows[17] = '{ACCESS, 16'hffff, 16'h0000, 1'b0, '0};
    dir_rows[18] = '{ACCESS, 16'h0000, 16'hffff, 1'b0, '0};

    // key pool: corners first, the rest random
    pool_x[0] = 16'h8000; pool_y[0] = 16'h8000;
    pool_x[1] = 16'h7fff; pool_y[1] = 16'h7fff;
    pool_x[2] = 16'h0000; pool_y[2] = 16'h0000;
    pool_x[3] = 16'hffff; pool_y[3] = 16'hffff;
    for (int i = 4; i < POOL_SIZE; i++) begin
      pool_x[i] = 16'($urandom);
      pool_y[i] = 16'($urandom);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECT; r++) begin
      send_req(dir_rows[r].op, dir_rows[r].kx, dir_rows[r].ky, pred);
      pending_rsp.push_back(dir_rows[r].typed ? dir_rows[r].rsp : pred);
    end

    // Random segments: a key pool above capacity forces evictions, a small one
    // mostly hits; a tenth of the keys are fresh noise.
    for (int s = 0; s < N_SEGS; s++) begin
      case ($urandom_range(0, 4))
        0: pool_n = 24;
        1: pool_n = 60;
        2: pool_n = 70;
        3: pool_n = 96;
        default: pool_n = POOL_SIZE;
      endcase
      if (s == 0) pool_n = POOL_SIZE;
      quiet = (s == 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_LEN; n++) begin
        op = ($urandom_range(0, 9) < 7) ? ACCESS : PROBE;
        if ($urandom_range(0, 9) == 0) begin
          kx = 16'($urandom);
          ky = 16'($urandom);
        end else begin
          j = $urandom_range(0, pool_n - 1);
          kx = pool_x[j];
          ky = pool_y[j];
        end
        send_req(op, kx, ky, pred);
        pending_rsp.push_back(pred);
      end
    end
    req_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d beats: %0d probes, %0d hits, %0d evictions", n_beats, n_probes,
             n_hits, n_evicts);
    $display("Peak occupancy %0d of %0d, %0d mismatches", peak_occ, CAP, errors);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
